// ----- hdl/blpl_pkg.sv -----
// Package: breakpoint table, per-segment constants and pipeline word types.
`timescale 1ns / 1ps
package blpl_pkg;

  // Number of breakpoints in use, clamped to 2..16
  localparam int BREAKPOINTS = 11;
  localparam int NB_USED = (BREAKPOINTS < 2) ? 2 : ((BREAKPOINTS > 16) ? 16 : BREAKPOINTS);
  localparam int NB_MAX = 16;

  // Field and datapath widths
  localparam int VW = 16;          // voltage word
  localparam int PCW = 7;          // percent word
  localparam int SEGW = 4;         // segment index
  localparam int DW = 9;           // offset inside a segment (width <= 500)
  localparam int PW = 16;          // offset times percent step
  localparam int RW = 23;          // reciprocal of segment width
  localparam int RSH = 26;         // reciprocal scale shift
  localparam int BW = PW + RW;     // full reciprocal product
  localparam int LATENCY = 5;      // start to done, in cycles

  // Breakpoints in mV, descending; entries past the eleventh repeat the bottom
  localparam logic [VW-1:0] BP [NB_MAX] = '{
    16'd1600, 16'd1405, 16'd1333, 16'd1293, 16'd1260, 16'd1232, 16'd1205, 16'd1183,
    16'd1170, 16'd1145, 16'd1100, 16'd1100, 16'd1100, 16'd1100, 16'd1100, 16'd1100
  };
  localparam logic [VW-1:0] BP_TOP = BP[0];
  localparam logic [VW-1:0] BP_BOTTOM = BP[NB_USED-1];

  // Percentage at each breakpoint
  localparam int PCT [NB_MAX] = '{
    100 - (100 * 0) / (NB_USED - 1),  100 - (100 * 1) / (NB_USED - 1),
    100 - (100 * 2) / (NB_USED - 1),  100 - (100 * 3) / (NB_USED - 1),
    100 - (100 * 4) / (NB_USED - 1),  100 - (100 * 5) / (NB_USED - 1),
    100 - (100 * 6) / (NB_USED - 1),  100 - (100 * 7) / (NB_USED - 1),
    100 - (100 * 8) / (NB_USED - 1),  100 - (100 * 9) / (NB_USED - 1),
    100 - (100 * 10) / (NB_USED - 1), 100 - (100 * 11) / (NB_USED - 1),
    100 - (100 * 12) / (NB_USED - 1), 100 - (100 * 13) / (NB_USED - 1),
    100 - (100 * 14) / (NB_USED - 1), 100 - (100 * 15) / (NB_USED - 1)
  };

  // Percent step across segment i (between breakpoint i-1 and i)
  localparam int STEP [NB_MAX] = '{
    0,                 PCT[0] - PCT[1],   PCT[1] - PCT[2],   PCT[2] - PCT[3],
    PCT[3] - PCT[4],   PCT[4] - PCT[5],   PCT[5] - PCT[6],   PCT[6] - PCT[7],
    PCT[7] - PCT[8],   PCT[8] - PCT[9],   PCT[9] - PCT[10],  PCT[10] - PCT[11],
    PCT[11] - PCT[12], PCT[12] - PCT[13], PCT[13] - PCT[14], PCT[14] - PCT[15]
  };

  // Width in mV of segment i; flat segments are never selected
  localparam int WD [NB_MAX] = '{
    1,                         int'(BP[0]) - int'(BP[1]),   int'(BP[1]) - int'(BP[2]),
    int'(BP[2]) - int'(BP[3]),   int'(BP[3]) - int'(BP[4]),   int'(BP[4]) - int'(BP[5]),
    int'(BP[5]) - int'(BP[6]),   int'(BP[6]) - int'(BP[7]),   int'(BP[7]) - int'(BP[8]),
    int'(BP[8]) - int'(BP[9]),   int'(BP[9]) - int'(BP[10]),  int'(BP[10]) - int'(BP[11]),
    int'(BP[11]) - int'(BP[12]), int'(BP[12]) - int'(BP[13]), int'(BP[13]) - int'(BP[14]),
    int'(BP[14]) - int'(BP[15])
  };

  // Rounded-up reciprocal of each width, scaled by 2^RSH; exact for products < 2^16
  localparam logic [RW-1:0] RECIP [NB_MAX] = '{
    RW'(((1 << RSH) + WD[0] - 1) / ((WD[0] == 0) ? 1 : WD[0])),
    RW'(((1 << RSH) + WD[1] - 1) / ((WD[1] == 0) ? 1 : WD[1])),
    RW'(((1 << RSH) + WD[2] - 1) / ((WD[2] == 0) ? 1 : WD[2])),
    RW'(((1 << RSH) + WD[3] - 1) / ((WD[3] == 0) ? 1 : WD[3])),
    RW'(((1 << RSH) + WD[4] - 1) / ((WD[4] == 0) ? 1 : WD[4])),
    RW'(((1 << RSH) + WD[5] - 1) / ((WD[5] == 0) ? 1 : WD[5])),
    RW'(((1 << RSH) + WD[6] - 1) / ((WD[6] == 0) ? 1 : WD[6])),
    RW'(((1 << RSH) + WD[7] - 1) / ((WD[7] == 0) ? 1 : WD[7])),
    RW'(((1 << RSH) + WD[8] - 1) / ((WD[8] == 0) ? 1 : WD[8])),
    RW'(((1 << RSH) + WD[9] - 1) / ((WD[9] == 0) ? 1 : WD[9])),
    RW'(((1 << RSH) + WD[10] - 1) / ((WD[10] == 0) ? 1 : WD[10])),
    RW'(((1 << RSH) + WD[11] - 1) / ((WD[11] == 0) ? 1 : WD[11])),
    RW'(((1 << RSH) + WD[12] - 1) / ((WD[12] == 0) ? 1 : WD[12])),
    RW'(((1 << RSH) + WD[13] - 1) / ((WD[13] == 0) ? 1 : WD[13])),
    RW'(((1 << RSH) + WD[14] - 1) / ((WD[14] == 0) ? 1 : WD[14])),
    RW'(((1 << RSH) + WD[15] - 1) / ((WD[15] == 0) ? 1 : WD[15]))
  };

  // Where a voltage falls on the curve
  typedef enum logic [1:0] {
    CLS_SEG   = 2'd0,
    CLS_FULL  = 2'd1,
    CLS_EMPTY = 2'd2
  } cls_t;

  // Word leaving the segment select stage
  typedef struct packed {
    logic            valid;
    cls_t            cls;
    logic [SEGW-1:0] seg;
    logic [VW-1:0]   volt;
  } sel_word_t;

  // Word leaving the interpolation stages
  typedef struct packed {
    logic            valid;
    cls_t            cls;
    logic [SEGW-1:0] seg;
    logic [BW-1:0]   prod;
  } interp_word_t;

endpackage

// ----- hdl/blpl_seg_select.sv -----
// Segment select stage: classifies the voltage and finds its segment.
`timescale 1ns / 1ps
module blpl_seg_select import blpl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [VW-1:0]   volt,
  output sel_word_t       sel
);

  cls_t            cls_next;
  logic [SEGW-1:0] seg_next;

  // Pick the first breakpoint not above the voltage
  always_comb begin
    seg_next = SEGW'(NB_USED - 1);
    for (int i = NB_USED - 1; i >= 1; i--) begin
      if (BP[i] <= volt) begin
        seg_next = SEGW'(i);
      end
    end
    if (volt >= BP_TOP) begin
      cls_next = CLS_FULL;
    end else if (volt <= BP_BOTTOM) begin
      cls_next = CLS_EMPTY;
    end else begin
      cls_next = CLS_SEG;
    end
  end

  // Register the word; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sel.valid <= 1'b0;
    end else begin
      sel.valid <= in_valid;
    end
    sel.cls  <= cls_next;
    sel.seg  <= seg_next;
    sel.volt <= volt;
  end

endmodule

// ----- hdl/blpl_interp.sv -----
// Interpolation stages: segment offset, scale by step, divide by width via reciprocal.
`timescale 1ns / 1ps
module blpl_interp import blpl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  sel_word_t    sel,
  output interp_word_t res
);

  // Offset stage
  logic            off_valid;
  cls_t            off_cls;
  logic [SEGW-1:0] off_seg;
  logic [DW-1:0]   off_d;
  logic [VW-1:0]   diff;

  // Scale stage
  logic            scl_valid;
  cls_t            scl_cls;
  logic [SEGW-1:0] scl_seg;
  logic [PW-1:0]   scl_prod;
  logic [PCW-1:0]  step_sel;

  assign diff = sel.volt - BP[sel.seg];
  assign step_sel = PCW'(STEP[off_seg]);

  // Valid bits advance every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      off_valid <= 1'b0;
      scl_valid <= 1'b0;
    end else begin
      off_valid <= sel.valid;
      scl_valid <= off_valid;
    end
  end

  // Offset above the lower breakpoint, below the segment width
  always_ff @(posedge clk) begin
    off_cls <= sel.cls;
    off_seg <= sel.seg;
    off_d   <= diff[DW-1:0];
  end

  // Scale the offset by the percent step
  always_ff @(posedge clk) begin
    scl_cls  <= off_cls;
    scl_seg  <= off_seg;
    scl_prod <= PW'(off_d) * PW'(step_sel);
  end

  // Multiply by the width reciprocal; the shift follows in the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= scl_valid;
    end
    res.cls  <= scl_cls;
    res.seg  <= scl_seg;
    res.prod <= BW'(scl_prod) * BW'(RECIP[scl_seg]);
  end

endmodule

// ----- hdl/battery_level_piecewise_linear_core.sv -----
// Top level: battery voltage to remaining-capacity percent, five-stage pipeline.
//
//   channel   ports                      handshake              dir
//   -------   -------------------------  ---------------------  ---
//   command   start, busy, voltage_mv    start & !busy          in
//   result    done, percent              done, one cycle        out
//
// One word is taken every cycle; busy is never raised.
// Each result appears on done in the order of its start.
// The depth is set by the segment compare, offset subtract, step multiply,
// reciprocal multiply and final shift-and-add, one register stage each.
// Synchronous reset clears all valid bits; words in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module battery_level_piecewise_linear_core import blpl_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [VW-1:0]  voltage_mv,
  output logic           done,
  output logic [PCW-1:0] percent
);

  sel_word_t      sel;
  interp_word_t   res;
  logic [PCW-1:0] quot;
  logic [PCW-1:0] pct_next;

  assign busy = 1'b0;

  blpl_seg_select u_select (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .volt     (voltage_mv),
    .sel      (sel)
  );

  blpl_interp u_interp (
    .clk (clk),
    .rst (rst),
    .sel (sel),
    .res (res)
  );

  // Drop the reciprocal scale and add the base percentage
  assign quot = res.prod[RSH +: PCW];

  always_comb begin
    case (res.cls)
      CLS_FULL:  pct_next = PCW'(100);
      CLS_EMPTY: pct_next = '0;
      default:   pct_next = PCW'(PCT[res.seg]) + quot;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
    percent <= pct_next;
  end

endmodule

// ----- hdl/blpl_checker.sv -----
// Port checker for the battery level core, bound to the top level.
`timescale 1ns / 1ps
module blpl_checker import blpl_pkg::*; (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic [VW-1:0]  voltage_mv,
  input logic           done,
  input logic [PCW-1:0] percent
);

  // Every accepted word yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted word gave no result after the pipeline latency");

  // No result without a word accepted the fixed latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted word");

  // Percent stays within range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (percent <= PCW'(100)))
    else $error("percent above 100");

  // Voltage at or above the top breakpoint reads as full
  a_full: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (voltage_mv >= BP_TOP)) |-> ##LATENCY (percent == PCW'(100)))
    else $error("full-scale voltage did not give 100 percent");

  // Voltage at or below the bottom breakpoint reads as empty
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (voltage_mv <= BP_BOTTOM)) |-> ##LATENCY (percent == '0))
    else $error("bottom voltage did not give 0 percent");

endmodule

bind battery_level_piecewise_linear_core blpl_checker u_blpl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .voltage_mv (voltage_mv),
  .done       (done),
  .percent    (percent)
);
